[hw/rtl/sdtq_pkg.sv]
// Shared types, codes and constants for the sorted deadline timer queue.
`default_nettype none

package sdtq_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int TAG_BITS_DEF = 16;

  localparam int TIME_W = 48;
  localparam int SEC_W  = 12;
  localparam int USEC_W = 24;
  localparam int ID_W   = 16;
  localparam int EV_W   = 3;
  localparam int OP_W   = 2;
  localparam int PROD_W = 32;

  localparam logic [PROD_W-1:0] USEC_PER_SEC = 32'd1000000;
  localparam logic [TIME_W-1:0] TIME_MAX     = {TIME_W{1'b1}};

  // Request operation codes.
  localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
  localparam logic [OP_W-1:0] OP_SPARE  = 2'd3;

  // Result event codes.
  localparam logic [EV_W-1:0] EV_IDLE      = 3'd0;
  localparam logic [EV_W-1:0] EV_ADDED     = 3'd1;
  localparam logic [EV_W-1:0] EV_BAD_DELAY = 3'd2;
  localparam logic [EV_W-1:0] EV_FULL      = 3'd3;
  localparam logic [EV_W-1:0] EV_REMOVED   = 3'd4;
  localparam logic [EV_W-1:0] EV_MARKED    = 3'd5;
  localparam logic [EV_W-1:0] EV_NOT_FOUND = 3'd6;
  localparam logic [EV_W-1:0] EV_EXPIRED   = 3'd7;

  // Scan index moves; the RAM read address follows the new index.
  typedef enum logic [2:0] {
    SEEK_HOLD, SEEK_ZERO, SEEK_TOP, SEEK_INC, SEEK_DEC
  } seek_t;

  // Entry writes.
  typedef enum logic [2:0] {
    WR_NONE, WR_MARK, WR_UP, WR_DOWN, WR_NEW_UP, WR_NEW_ZERO
  } wr_t;

  typedef enum logic [1:0] {
    OCC_HOLD, OCC_INC, OCC_DEC
  } occ_op_t;

  typedef enum logic [1:0] {
    TAGSEL_ZERO, TAGSEL_NEXT, TAGSEL_TARGET, TAGSEL_DATA
  } tagsel_t;

  typedef struct packed {
    logic            load;
    logic            tick_now;
    logic            calc;
    logic            dl_set;
    seek_t           seek;
    wr_t             wr;
    occ_op_t         occ_op;
    logic            tag_inc;
    logic            respond;
    logic [EV_W-1:0] resp_code;
    tagsel_t         tag_sel;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            zero_delay;
    logic            full;
    logic            occ_zero;
    logic            idx_zero;
    logic            idx_last;
    logic            head_due;
    logic            data_canc;
    logic            data_later;
    logic            tag_match;
  } sts_t;

endpackage

`default_nettype wire

[hw/rtl/sdtq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sdtq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[hw/rtl/sdtq_ctrl.sv]
// Controller state machine of the timer queue.
`default_nettype none

module sdtq_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire sdtq_pkg::sts_t sts,
  output sdtq_pkg::cmd_t     cmd
);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_DECODE  = 8'b0000_0010,
    S_SUM     = 8'b0000_0100,
    S_INS     = 8'b0000_1000,
    S_WRNEW   = 8'b0001_0000,
    S_TICKCHK = 8'b0010_0000,
    S_FIND    = 8'b0100_0000,
    S_SHIFT   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.seek      = sdtq_pkg::SEEK_HOLD;
    cmd.wr        = sdtq_pkg::WR_NONE;
    cmd.occ_op    = sdtq_pkg::OCC_HOLD;
    cmd.resp_code = sdtq_pkg::EV_IDLE;
    cmd.tag_sel   = sdtq_pkg::TAGSEL_ZERO;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.op)
          sdtq_pkg::OP_TICK: begin
            cmd.tick_now = 1'b1;
            if (sts.occ_zero) begin
              cmd.respond = 1'b1;
              state_nxt   = S_IDLE;
            end else begin
              cmd.seek  = sdtq_pkg::SEEK_ZERO;
              state_nxt = S_TICKCHK;
            end
          end
          sdtq_pkg::OP_ADD: begin
            // The zero-delay check takes priority over the full check.
            if (sts.zero_delay) begin
              cmd.respond   = 1'b1;
              cmd.resp_code = sdtq_pkg::EV_BAD_DELAY;
              state_nxt     = S_IDLE;
            end else if (sts.full) begin
              cmd.respond   = 1'b1;
              cmd.resp_code = sdtq_pkg::EV_FULL;
              state_nxt     = S_IDLE;
            end else begin
              cmd.calc  = 1'b1;
              state_nxt = S_SUM;
            end
          end
          sdtq_pkg::OP_REMOVE: begin
            if (sts.occ_zero) begin
              cmd.respond   = 1'b1;
              cmd.resp_code = sdtq_pkg::EV_NOT_FOUND;
              state_nxt     = S_IDLE;
            end else begin
              cmd.seek  = sdtq_pkg::SEEK_ZERO;
              state_nxt = S_FIND;
            end
          end
          default: begin
            cmd.respond = 1'b1;
            state_nxt   = S_IDLE;
          end
        endcase
      end
      S_SUM: begin
        cmd.dl_set = 1'b1;
        if (sts.occ_zero) begin
          state_nxt = S_WRNEW;
        end else begin
          cmd.seek  = sdtq_pkg::SEEK_TOP;
          state_nxt = S_INS;
        end
      end
      S_INS: begin
        // Walk down from the tail, moving every later entry up by one.
        if (sts.data_later) begin
          cmd.wr = sdtq_pkg::WR_UP;
          if (sts.idx_zero) begin
            state_nxt = S_WRNEW;
          end else begin
            cmd.seek = sdtq_pkg::SEEK_DEC;
          end
        end else begin
          cmd.wr        = sdtq_pkg::WR_NEW_UP;
          cmd.occ_op    = sdtq_pkg::OCC_INC;
          cmd.tag_inc   = 1'b1;
          cmd.respond   = 1'b1;
          cmd.resp_code = sdtq_pkg::EV_ADDED;
          cmd.tag_sel   = sdtq_pkg::TAGSEL_NEXT;
          state_nxt     = S_IDLE;
        end
      end
      S_WRNEW: begin
        cmd.wr        = sdtq_pkg::WR_NEW_ZERO;
        cmd.occ_op    = sdtq_pkg::OCC_INC;
        cmd.tag_inc   = 1'b1;
        cmd.respond   = 1'b1;
        cmd.resp_code = sdtq_pkg::EV_ADDED;
        cmd.tag_sel   = sdtq_pkg::TAGSEL_NEXT;
        state_nxt     = S_IDLE;
      end
      S_TICKCHK: begin
        cmd.respond = 1'b1;
        if (sts.head_due) begin
          if (!sts.data_canc) begin
            cmd.resp_code = sdtq_pkg::EV_EXPIRED;
            cmd.tag_sel   = sdtq_pkg::TAGSEL_DATA;
          end
          if (sts.idx_last) begin
            cmd.occ_op = sdtq_pkg::OCC_DEC;
            state_nxt  = S_IDLE;
          end else begin
            cmd.seek  = sdtq_pkg::SEEK_INC;
            state_nxt = S_SHIFT;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_FIND: begin
        if (sts.tag_match) begin
          if (sts.idx_zero) begin
            // The armed head is only marked, never taken out.
            cmd.wr        = sdtq_pkg::WR_MARK;
            cmd.respond   = 1'b1;
            cmd.resp_code = sdtq_pkg::EV_MARKED;
            cmd.tag_sel   = sdtq_pkg::TAGSEL_TARGET;
            state_nxt     = S_IDLE;
          end else begin
            cmd.respond   = 1'b1;
            cmd.resp_code = sdtq_pkg::EV_REMOVED;
            cmd.tag_sel   = sdtq_pkg::TAGSEL_TARGET;
            if (sts.idx_last) begin
              cmd.occ_op = sdtq_pkg::OCC_DEC;
              state_nxt  = S_IDLE;
            end else begin
              cmd.seek  = sdtq_pkg::SEEK_INC;
              state_nxt = S_SHIFT;
            end
          end
        end else if (sts.idx_last) begin
          cmd.respond   = 1'b1;
          cmd.resp_code = sdtq_pkg::EV_NOT_FOUND;
          state_nxt     = S_IDLE;
        end else begin
          cmd.seek = sdtq_pkg::SEEK_INC;
        end
      end
      S_SHIFT: begin
        // Close the gap: each later entry moves down by one.
        cmd.wr = sdtq_pkg::WR_DOWN;
        if (sts.idx_last) begin
          cmd.occ_op = sdtq_pkg::OCC_DEC;
          state_nxt  = S_IDLE;
        end else begin
          cmd.seek = sdtq_pkg::SEEK_INC;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/sdtq_dpath.sv]
// Datapath of the timer queue: clock, deadline math, entry RAM and scan index.
`default_nettype none

module sdtq_dpath #(
  parameter int CAPACITY = sdtq_pkg::CAPACITY_DEF,
  parameter int TAG_BITS = sdtq_pkg::TAG_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [sdtq_pkg::OP_W-1:0]     in_op,
  input  wire logic [sdtq_pkg::SEC_W-1:0]    in_delay_sec,
  input  wire logic [sdtq_pkg::USEC_W-1:0]   in_delay_usec,
  input  wire logic [sdtq_pkg::ID_W-1:0]     in_target_id,
  input  wire sdtq_pkg::cmd_t                cmd,
  output sdtq_pkg::sts_t                     sts,
  output logic                               out_strobe,
  output logic [sdtq_pkg::EV_W-1:0]          out_event_res,
  output logic [sdtq_pkg::ID_W-1:0]          out_timer_tag
);

  localparam int IDXW = $clog2(CAPACITY);
  localparam int OCCW = $clog2(CAPACITY + 1);
  localparam int TW   = sdtq_pkg::TIME_W;
  localparam int ENTW = 1 + TAG_BITS + TW;
  localparam int CMPW = (TAG_BITS > sdtq_pkg::ID_W) ? TAG_BITS : sdtq_pkg::ID_W;
  localparam int PW   = sdtq_pkg::PROD_W;

  logic [sdtq_pkg::OP_W-1:0]   op_r;
  logic [sdtq_pkg::SEC_W-1:0]  sec_r;
  logic [sdtq_pkg::USEC_W-1:0] usec_r;
  logic [sdtq_pkg::ID_W-1:0]   target_r;
  logic [TW-1:0]               now_r, now_nxt;
  logic [PW-1:0]               prod_r;
  logic [TW:0]                 part_r;
  logic [TW+1:0]               sum;
  logic [TW-1:0]               dl_r, dl_nxt;
  logic [IDXW-1:0]             idx_r, idx_nxt;
  logic [OCCW-1:0]             occ_r;
  logic [TAG_BITS-1:0]         next_tag_r;
  logic                        strobe_r;
  logic [sdtq_pkg::EV_W-1:0]   event_r;
  logic [sdtq_pkg::ID_W-1:0]   tag_r, tag_nxt;

  logic                        we;
  logic [IDXW-1:0]             waddr;
  logic [ENTW-1:0]             wdata;
  logic [ENTW-1:0]             rdata;
  logic [TW-1:0]               rd_dl;
  logic [TAG_BITS-1:0]         rd_tag;
  logic                        rd_canc;

  assign rd_dl   = rdata[TW-1:0];
  assign rd_tag  = rdata[TW +: TAG_BITS];
  assign rd_canc = rdata[ENTW-1];

  assign now_nxt = (now_r == sdtq_pkg::TIME_MAX) ? now_r : now_r + TW'(1);
  assign sum     = (TW+2)'(part_r) + (TW+2)'(prod_r);
  assign dl_nxt  = (sum > (TW+2)'(sdtq_pkg::TIME_MAX)) ? sdtq_pkg::TIME_MAX : sum[TW-1:0];

  always_comb begin
    case (cmd.seek)
      sdtq_pkg::SEEK_ZERO: idx_nxt = '0;
      sdtq_pkg::SEEK_TOP:  idx_nxt = IDXW'(occ_r - OCCW'(1));
      sdtq_pkg::SEEK_INC:  idx_nxt = idx_r + IDXW'(1);
      sdtq_pkg::SEEK_DEC:  idx_nxt = idx_r - IDXW'(1);
      default:             idx_nxt = idx_r;
    endcase
  end

  always_comb begin
    we    = 1'b1;
    waddr = idx_r;
    wdata = rdata;
    case (cmd.wr)
      sdtq_pkg::WR_MARK: begin
        wdata = {1'b1, rd_tag, rd_dl};
      end
      sdtq_pkg::WR_UP: begin
        waddr = idx_r + IDXW'(1);
      end
      sdtq_pkg::WR_DOWN: begin
        waddr = idx_r - IDXW'(1);
      end
      sdtq_pkg::WR_NEW_UP: begin
        waddr = idx_r + IDXW'(1);
        wdata = {1'b0, next_tag_r, dl_r};
      end
      sdtq_pkg::WR_NEW_ZERO: begin
        waddr = '0;
        wdata = {1'b0, next_tag_r, dl_r};
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_comb begin
    case (cmd.tag_sel)
      sdtq_pkg::TAGSEL_NEXT:   tag_nxt = sdtq_pkg::ID_W'(next_tag_r);
      sdtq_pkg::TAGSEL_TARGET: tag_nxt = target_r;
      sdtq_pkg::TAGSEL_DATA:   tag_nxt = sdtq_pkg::ID_W'(rd_tag);
      default:                 tag_nxt = '0;
    endcase
  end

  sdtq_ram #(
    .WIDTH(ENTW),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(idx_nxt),
    .rdata(rdata)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r      <= '0;
      occ_r      <= '0;
      next_tag_r <= '0;
      idx_r      <= '0;
      strobe_r   <= 1'b0;
    end else begin
      if (cmd.tick_now) begin
        now_r <= now_nxt;
      end
      case (cmd.occ_op)
        sdtq_pkg::OCC_INC: occ_r <= occ_r + OCCW'(1);
        sdtq_pkg::OCC_DEC: occ_r <= occ_r - OCCW'(1);
        default:           occ_r <= occ_r;
      endcase
      if (cmd.tag_inc) begin
        next_tag_r <= next_tag_r + TAG_BITS'(1);
      end
      idx_r    <= idx_nxt;
      strobe_r <= cmd.respond;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_op;
      sec_r    <= in_delay_sec;
      usec_r   <= in_delay_usec;
      target_r <= in_target_id;
    end
    if (cmd.calc) begin
      prod_r <= PW'(sec_r) * sdtq_pkg::USEC_PER_SEC;
      part_r <= (TW+1)'(now_r) + (TW+1)'(usec_r);
    end
    if (cmd.dl_set) begin
      dl_r <= dl_nxt;
    end
    if (cmd.respond) begin
      event_r <= cmd.resp_code;
      tag_r   <= tag_nxt;
    end
  end

  always_comb begin
    sts.op         = op_r;
    sts.zero_delay = (sec_r == '0) && (usec_r == '0);
    sts.full       = (occ_r == OCCW'(CAPACITY));
    sts.occ_zero   = (occ_r == '0);
    sts.idx_zero   = (idx_r == '0);
    sts.idx_last   = ((OCCW'(idx_r) + OCCW'(1)) == occ_r);
    sts.head_due   = (rd_dl <= now_r);
    sts.data_canc  = rd_canc;
    sts.data_later = (rd_dl > dl_r);
    sts.tag_match  = (CMPW'(rd_tag) == CMPW'(target_r));
  end

  assign out_strobe    = strobe_r;
  assign out_event_res = event_r;
  assign out_timer_tag = tag_r;

endmodule

`default_nettype wire

[hw/rtl/sorted_deadline_timer_queue_unit.sv]
// Top level of the sorted deadline timer queue: controller, datapath and checks.
//
//   Channel   Ports                                         Handshake
//   request   in_op, in_delay_sec, in_delay_usec,           start && !busy
//             in_target_id
//   result    out_event_res, out_timer_tag                  out_strobe, one cycle
//
// Every request gives one result, strobed in the cycle after the controller picks it.
// Tick: if the head is due it is popped and every remaining entry moves down by one
//   (at most CAPACITY-1) to compact the queue, through the single RAM port pair.
// Add: later-deadline entries move up and the new one is written; rejects skip both.
// Remove: entries are scanned from the head for the tag, then later ones move down.
// Reset is synchronous; only counters and control clear, the entry RAM needs no
// clearing pass. The receiver cannot stall; busy holds off new requests.
`default_nettype none

module sorted_deadline_timer_queue_unit #(
  parameter int CAPACITY = sdtq_pkg::CAPACITY_DEF,
  parameter int TAG_BITS = sdtq_pkg::TAG_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [sdtq_pkg::OP_W-1:0]   in_op,
  input  wire logic [sdtq_pkg::SEC_W-1:0]  in_delay_sec,
  input  wire logic [sdtq_pkg::USEC_W-1:0] in_delay_usec,
  input  wire logic [sdtq_pkg::ID_W-1:0]   in_target_id,
  output logic                             out_strobe,
  output logic [sdtq_pkg::EV_W-1:0]        out_event_res,
  output logic [sdtq_pkg::ID_W-1:0]        out_timer_tag
);

  sdtq_pkg::cmd_t cmd;
  sdtq_pkg::sts_t sts;

  sdtq_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .busy (busy),
    .sts  (sts),
    .cmd  (cmd)
  );

  sdtq_dpath #(
    .CAPACITY(CAPACITY),
    .TAG_BITS(TAG_BITS)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_op        (in_op),
    .in_delay_sec (in_delay_sec),
    .in_delay_usec(in_delay_usec),
    .in_target_id (in_target_id),
    .cmd          (cmd),
    .sts          (sts),
    .out_strobe   (out_strobe),
    .out_event_res(out_event_res),
    .out_timer_tag(out_timer_tag)
  );

`ifndef SYNTH
  // A result only follows a cycle in which a request was being worked on.
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result strobe without a request in progress");

  // One request never yields two results in a row.
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("back-to-back result strobes");

  // An insertion never happens into a full queue.
  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.occ_op == sdtq_pkg::OCC_INC) |-> !sts.full)
    else $error("entry added to a full queue");

  // Entry writes happen only while a request is in progress.
  a_write_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr != sdtq_pkg::WR_NONE) |-> busy)
    else $error("entry RAM written while idle");
`endif

endmodule

`default_nettype wire
